// ===== hw/rtl/fsa_pkg.sv =====
package fsa_pkg;

  localparam int ACTION_W     = 2;
  localparam int ID_W         = 16;
  localparam int OFFSET_W     = 16;
  localparam int KIND_W       = 2;
  localparam int REG_INDEX_W  = 4;
  localparam int MEM_OFFSET_W = 17;

  localparam int NUM_REGS_DEFAULT   = 11;
  localparam int FRAME_BIAS_DEFAULT = 76;

  typedef enum logic [ACTION_W-1:0] {
    ACT_REQUEST = 2'd0,
    ACT_FLUSH   = 2'd1,
    ACT_REINIT  = 2'd2,
    ACT_IGNORE  = 2'd3
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANT = 2'd0,
    KIND_STORE = 2'd1,
    KIND_LOAD  = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SPILL,
    S_FILL,
    S_GRANT,
    S_FLUSH,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic  capture;     // load the accepted item
    logic  latch_sel;   // register the target slot (hit or next to allocate)
    logic  emit;        // load the result register
    kind_t kind;
    logic  last;
    logic  fill_write;  // write the new mapping, advance allocation state
    logic  flush_step;  // store from the oldest slot and release it
    logic  clear_pool;  // drop every mapping
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_t action;
    logic    hit;
    logic    full;
    logic    empty;
    logic    out_free;
  } status_t;

endpackage

// ===== hw/rtl/fsa_if.sv =====
interface fsa_req_if;
  import fsa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ID_W-1:0]     temp_id;
  logic [OFFSET_W-1:0] temp_offset;

  modport source (output valid, action, temp_id, temp_offset, input ready);
  modport sink   (input valid, action, temp_id, temp_offset, output ready);
endinterface

interface fsa_rsp_if;
  import fsa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [REG_INDEX_W-1:0]  reg_index;
  logic [MEM_OFFSET_W-1:0] mem_offset;
  logic                    last;

  modport source (output valid, kind, reg_index, mem_offset, last, input ready);
  modport sink   (input valid, kind, reg_index, mem_offset, last, output ready);
endinterface

// ===== hw/rtl/fifo_register_spill_allocator_top.sv =====
// Sequence: a hit passes through the look and grant states, and the grant is registered
//   in the result register; a miss gives store (if full), load, grant one per cycle from
//   then on while the result register is free; a flush gives one store per held register
//   and then done; reinitialize passes through the look and done states and gives done.
// Flow: one item in flight, paced by the controller through the single result register.
// Reset (rst, synchronous): pool empty, outside_main cleared, no result pending.
module fifo_register_spill_allocator_top #(
  parameter int NUM_REGS   = fsa_pkg::NUM_REGS_DEFAULT,
  parameter int FRAME_BIAS = fsa_pkg::FRAME_BIAS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  fsa_req_if.sink    req,
  fsa_rsp_if.source  rsp
);
  import fsa_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Controller: sequences one item at a time. The request is taken only in the
  // idle state, but a result still waiting downstream does not block it; the
  // result register decouples the two sides.
  fsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: captured item, slot table (flops, compared in parallel for the
  // hit check), FIFO pointer and count, offset bias, result register.
  fsa_datapath #(
    .NUM_REGS   (NUM_REGS),
    .FRAME_BIAS (FRAME_BIAS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_action      (req.action),
    .in_temp_id     (req.temp_id),
    .in_temp_offset (req.temp_offset),
    .cmd            (cmd),
    .status         (status),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_kind       (rsp.kind),
    .rsp_reg_index  (rsp.reg_index),
    .rsp_mem_offset (rsp.mem_offset),
    .rsp_last       (rsp.last)
  );

endmodule

// ===== hw/rtl/fsa_ctrl.sv =====
module fsa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fsa_pkg::status_t status,
  output fsa_pkg::cmd_t    cmd
);
  import fsa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.kind   = KIND_GRANT;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.latch_sel = 1'b1;
        case (status.action)
          ACT_REQUEST: begin
            if (status.hit) begin
              state_next = S_GRANT;
            end else if (status.full) begin
              state_next = S_SPILL;
            end else begin
              state_next = S_FILL;
            end
          end
          ACT_FLUSH:  state_next = S_FLUSH;
          ACT_REINIT: state_next = S_DONE;
          default:    state_next = S_IDLE;
        endcase
      end
      S_SPILL: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_STORE;
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        if (status.out_free) begin
          cmd.emit       = 1'b1;
          cmd.kind       = KIND_LOAD;
          cmd.fill_write = 1'b1;
          state_next     = S_GRANT;
        end
      end
      S_GRANT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_GRANT;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (status.empty) begin
          state_next = S_DONE;
        end else if (status.out_free) begin
          cmd.emit       = 1'b1;
          cmd.kind       = KIND_STORE;
          cmd.flush_step = 1'b1;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.emit       = 1'b1;
          cmd.kind       = KIND_DONE;
          cmd.last       = 1'b1;
          cmd.clear_pool = (status.action == ACT_REINIT);
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/fsa_datapath.sv =====
module fsa_datapath #(
  parameter int NUM_REGS   = fsa_pkg::NUM_REGS_DEFAULT,
  parameter int FRAME_BIAS = fsa_pkg::FRAME_BIAS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata,
  input  logic [fsa_pkg::ACTION_W-1:0]     in_action,
  input  logic [fsa_pkg::ID_W-1:0]         in_temp_id,
  input  logic [fsa_pkg::OFFSET_W-1:0]     in_temp_offset,
  input  fsa_pkg::cmd_t                    cmd,
  output fsa_pkg::status_t                 status,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output logic [fsa_pkg::KIND_W-1:0]       rsp_kind,
  output logic [fsa_pkg::REG_INDEX_W-1:0]  rsp_reg_index,
  output logic [fsa_pkg::MEM_OFFSET_W-1:0] rsp_mem_offset,
  output logic                             rsp_last
);
  import fsa_pkg::*;

  localparam int IdxW = $clog2(NUM_REGS);
  localparam int CntW = $clog2(NUM_REGS + 1);
  localparam int SumW = CntW + 1;

  // configuration
  logic outside_main;

  // captured item
  action_t             act;
  logic [ID_W-1:0]     tid;
  logic [OFFSET_W-1:0] toff;

  // pool state
  logic [ID_W-1:0]     slot_temp   [NUM_REGS];
  logic [OFFSET_W-1:0] slot_offset [NUM_REGS];
  logic [NUM_REGS-1:0] slot_valid;
  logic [IdxW-1:0]     oldest_ptr;
  logic [CntW-1:0]     held_count;
  logic [IdxW-1:0]     sel;

  logic [NUM_REGS-1:0] hit_vec;
  logic [IdxW-1:0]     hit_idx;
  logic [SumW-1:0]     alloc_sum;
  logic [IdxW-1:0]     alloc_idx;
  logic [IdxW-1:0]     oldest_inc;
  logic [IdxW-1:0]     st_idx;
  logic                full;
  logic                out_free;
  logic [MEM_OFFSET_W-1:0] bias;
  logic [OFFSET_W-1:0]     raw_off;
  logic [REG_INDEX_W-1:0]  idx_mux;
  logic [MEM_OFFSET_W-1:0] off_mux;

  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      hit_vec[i] = slot_valid[i] && (slot_temp[i] == tid);
    end
    hit_idx = '0;
    for (int i = NUM_REGS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = IdxW'(i);
    end
  end

  assign full       = (held_count == CntW'(NUM_REGS));
  assign alloc_sum  = SumW'(oldest_ptr) + SumW'(held_count);
  assign alloc_idx  = (alloc_sum >= SumW'(NUM_REGS)) ? IdxW'(alloc_sum - SumW'(NUM_REGS))
                                                     : IdxW'(alloc_sum);
  assign oldest_inc = (oldest_ptr == IdxW'(NUM_REGS - 1)) ? '0 : oldest_ptr + 1'b1;
  assign out_free   = !rsp_valid || rsp_ready;

  assign status.action   = act;
  assign status.hit      = |hit_vec;
  assign status.full     = full;
  assign status.empty    = (held_count == '0);
  assign status.out_free = out_free;

  // result fields
  assign bias   = outside_main ? MEM_OFFSET_W'(FRAME_BIAS) : '0;
  assign st_idx = cmd.flush_step ? oldest_ptr : sel;

  always_comb begin
    raw_off = '0;
    idx_mux = '0;
    off_mux = '0;
    case (cmd.kind)
      KIND_GRANT: begin
        idx_mux = REG_INDEX_W'(sel);
      end
      KIND_STORE: begin
        idx_mux = REG_INDEX_W'(st_idx);
        raw_off = slot_offset[st_idx];
        off_mux = MEM_OFFSET_W'(raw_off) + bias;
      end
      KIND_LOAD: begin
        idx_mux = REG_INDEX_W'(sel);
        raw_off = toff;
        off_mux = MEM_OFFSET_W'(raw_off) + bias;
      end
      default: begin
        idx_mux = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outside_main <= 1'b0;
    end else if (cfg_we) begin
      outside_main <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act  <= action_t'(in_action);
      tid  <= in_temp_id;
      toff <= in_temp_offset;
    end
    if (cmd.latch_sel) begin
      sel <= status.hit ? hit_idx : (full ? oldest_ptr : alloc_idx);
    end
    if (cmd.fill_write) begin
      slot_temp[sel]   <= tid;
      slot_offset[sel] <= toff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      oldest_ptr <= '0;
      held_count <= '0;
    end else if (cmd.clear_pool) begin
      slot_valid <= '0;
      oldest_ptr <= '0;
      held_count <= '0;
    end else if (cmd.fill_write) begin
      slot_valid[sel] <= 1'b1;
      if (full) begin
        oldest_ptr <= oldest_inc;  // sel is the evicted oldest slot
      end else begin
        held_count <= held_count + 1'b1;
      end
    end else if (cmd.flush_step) begin
      slot_valid[oldest_ptr] <= 1'b0;
      oldest_ptr             <= oldest_inc;
      held_count             <= held_count - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_kind       <= cmd.kind;
      rsp_reg_index  <= idx_mux;
      rsp_mem_offset <= off_mux;
      rsp_last       <= cmd.last;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    held_count <= CntW'(NUM_REGS))
    else $error("held count above pool size");

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_valid) == int'(held_count))
    else $error("held count disagrees with valid slots");

  a_emit_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!rsp_valid || rsp_ready))
    else $error("result overwritten before taken");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("temporary mapped in two slots");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_pool |=> (held_count == '0) && (slot_valid == '0))
    else $error("pool not empty after reinitialize");
`endif

endmodule
